// ----- src/srma_pkg.sv -----
// Shared types, constants and arithmetic for the sonar range moving average.
package srma_pkg;

  localparam int SAMPLE_W = 12;
  localparam int MM_W     = 12;
  localparam int CHANNELS = 3;
  localparam int WINDOW   = 5;

  localparam int MM_MIN   = 200;
  localparam int MM_MAX   = 4000;
  localparam int MM_SPAN  = 3800;
  localparam int ADC_FULL = 4095;
  localparam int MM_FILL  = 2000;

  // floor(s * MM_SPAN / ADC_FULL) as s * MAP_MUL >> MAP_SHIFT, exact for 12-bit s
  localparam int MAP_SHIFT = 2 * SAMPLE_W;
  localparam longint unsigned MAP_MUL =
    ((longint'(MM_SPAN) << MAP_SHIFT) + longint'(ADC_FULL) - 1) / longint'(ADC_FULL);
  localparam int MAP_PROD_W = SAMPLE_W + MAP_SHIFT + 1;

  // running window sum
  localparam int SUM_W    = $clog2(WINDOW * MM_MAX + 1);
  localparam int SUM_INIT = WINDOW * MM_FILL;

  // floor(sum / WINDOW) as sum * DIV_MUL >> DIV_SHIFT, exact below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam longint unsigned DIV_MUL =
    ((longint'(1) << DIV_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam int DIV_PROD_W = SUM_W + DIV_SHIFT + 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] front_sample;
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;
  } sample_t;

  typedef struct packed {
    logic [MM_W-1:0] front_mm;
    logic [MM_W-1:0] left_mm;
    logic [MM_W-1:0] right_mm;
  } result_t;

  // index 0 front, 1 left, 2 right
  typedef logic [CHANNELS-1:0][MM_W-1:0]  mm_vec_t;
  typedef logic [CHANNELS-1:0][SUM_W-1:0] sum_vec_t;

  function automatic logic [MM_W-1:0] map_mm(input logic [SAMPLE_W-1:0] s);
    logic [MAP_PROD_W-1:0] prod;
    logic [MM_W-1:0]       q;
    logic [MM_W:0]         mm;
    prod = MAP_PROD_W'(s) * MAP_PROD_W'(MAP_MUL);
    q    = prod[MAP_SHIFT +: MM_W];
    mm   = (MM_W+1)'(MM_MIN) + (MM_W+1)'(q);
    if (mm < (MM_W+1)'(MM_MIN)) mm = (MM_W+1)'(MM_MIN);
    if (mm > (MM_W+1)'(MM_MAX)) mm = (MM_W+1)'(MM_MAX);
    return mm[MM_W-1:0];
  endfunction

  function automatic logic [MM_W-1:0] mean_of(input logic [SUM_W-1:0] sum);
    logic [DIV_PROD_W-1:0] prod;
    prod = DIV_PROD_W'(sum) * DIV_PROD_W'(DIV_MUL);
    return prod[DIV_SHIFT +: MM_W];
  endfunction

endpackage

// ----- src/srma_map.sv -----
// Converter sample to millimeter mapping stage, one register deep.
module srma_map (
  input  logic             clk_i,
  input  logic             load_i,
  input  srma_pkg::sample_t sample_i,
  output srma_pkg::mm_vec_t mm_o
);
  import srma_pkg::*;

  mm_vec_t mm_d, mm_q;

  always_comb begin
    mm_d[0] = map_mm(sample_i.front_sample);
    mm_d[1] = map_mm(sample_i.left_sample);
    mm_d[2] = map_mm(sample_i.right_sample);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mm_q <= mm_d;
    end
  end

  assign mm_o = mm_q;

endmodule

// ----- src/srma_cell.sv -----
// One history cell: holds one window entry for every channel.
module srma_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  srma_pkg::mm_vec_t d_i,
  output srma_pkg::mm_vec_t q_o
);
  import srma_pkg::*;

  mm_vec_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        entry_q[c] <= MM_W'(MM_FILL);
      end
    end else if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ----- src/srma_window.sv -----
// Chain of history cells with a running sum per channel.
module srma_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  srma_pkg::mm_vec_t  mm_i,
  output srma_pkg::sum_vec_t sum_o
);
  import srma_pkg::*;

  mm_vec_t  tap [WINDOW+1];
  sum_vec_t sum_d, sum_q;

  assign tap[0] = mm_i;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    srma_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_i),
      .d_i     (tap[k]),
      .q_o     (tap[k+1])
    );
  end

  // the entry leaving the last cell is the one being replaced
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sum_d[c] = SUM_W'(({1'b0, sum_q[c]} + (SUM_W+1)'(mm_i[c]))
                        - (SUM_W+1)'(tap[WINDOW][c]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_q[c] <= SUM_W'(SUM_INIT);
      end
    end else if (shift_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

  property p_sum_bound(int c);
    @(posedge clk_i) disable iff (!rst_ni)
      sum_q[c] <= SUM_W'(WINDOW * MM_MAX);
  endproperty

  a_front_sum_bound: assert property (p_sum_bound(0)) else $error("front sum overflow");
  a_left_sum_bound:  assert property (p_sum_bound(1)) else $error("left sum overflow");
  a_right_sum_bound: assert property (p_sum_bound(2)) else $error("right sum overflow");

endmodule

// ----- src/sonar_range_moving_average.sv -----
// Sonar range moving average: top level with three-stage item pipeline.
//
// Input channel: in_valid_i / in_stall_o carry one sample triple (front, left,
// right, 12-bit converter codes). Output channel: out_valid_o / out_stall_i
// carry the averaged distances in millimeters, one result per input item.
// Each sample maps to 200 + floor(s * 3800 / 4095) mm; each channel keeps the
// last five values in a chain of shift cells with a running sum, and the
// result is the truncated mean of that window.
// The accepting edge loads the map stage; after that the cell chain shifts and the
// sum updates, then the mean is registered in the output register, and a stall
// can hold an item between these steps.
// Throughput: one item per cycle while the receiver does not stall; each stage
// takes a new item whenever it is empty or its successor moves on, so stalls
// only back up stage by stage. When the receiver stalls, the result holds and
// the pipeline fills; in_stall_o rises only once all three stages hold items.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets every window
// entry to 2000 mm, so the first results average against that fill value.
module sonar_range_moving_average (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srma_pkg::sample_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srma_pkg::result_t out_data_o
);
  import srma_pkg::*;

  logic     v1_q, v2_q, v3_q;
  logic     adv1, adv2, adv3;
  mm_vec_t  mm1;
  sum_vec_t sum2;
  result_t  out_d, out_q;

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o = !adv1;

  srma_map u_map (
    .clk_i    (clk_i),
    .load_i   (adv1),
    .sample_i (in_data_i),
    .mm_o     (mm1)
  );

  // cells shift exactly when a mapped item moves into the sum stage
  srma_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (adv2 && v1_q),
    .mm_i    (mm1),
    .sum_o   (sum2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_comb begin
    out_d.front_mm = mean_of(sum2[0]);
    out_d.left_mm  = mean_of(sum2[1]);
    out_d.right_mm = mean_of(sum2[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with a free stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted item lost at map stage");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (out_q.front_mm >= MM_W'(MM_MIN) && out_q.front_mm <= MM_W'(MM_MAX)
           && out_q.left_mm >= MM_W'(MM_MIN) && out_q.left_mm <= MM_W'(MM_MAX)
           && out_q.right_mm >= MM_W'(MM_MIN) && out_q.right_mm <= MM_W'(MM_MAX)))
    else $error("mean out of range");

endmodule
